// ----- rtl/gbn_pkg.sv -----
// Shared types and constants for the go-back-N sender window.
// Used by gbn_out_reg, gbn_ctrl and the top level; no dependencies.
package gbn_pkg;

  localparam int WINDOW_DEF    = 8;
  localparam int SEQ_BITS_DEF  = 16;

  localparam int PAYLOAD_W     = 8;
  localparam int ACK_W         = 16;
  localparam int FSEQ_W        = 16;
  localparam int CNT_OUT_W     = 4;
  localparam int TIMER_W       = 16;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 32;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd5;
  localparam logic [TIMER_W-1:0] TIMER_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_PRODUCE = 2'd0,
    KIND_SEND    = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_TICK    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_STATUS  = 3'd0,
    OUT_SENT    = 3'd1,
    OUT_RETX    = 3'd2,
    OUT_REFUSED = 3'd3,
    OUT_ACK_IGN = 3'd4
  } out_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] waiting;
    logic [CNT_OUT_W-1:0] free;
    logic [PAYLOAD_W-1:0] data;
    logic [FSEQ_W-1:0]    seq;
    out_kind_t            kind;
    logic                 last;
  } res_t;

endpackage

// ----- rtl/gbn_byte_ram.sv -----
// Slot byte store: one write port, one registered read port.
// Depends on nothing; sized by the top level's window parameter.
module gbn_byte_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/gbn_out_reg.sv -----
// Result output register between the controller and the master-side stream.
// Depends on gbn_pkg for the result struct.
module gbn_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  gbn_pkg::res_t res_in,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output gbn_pkg::res_t res_out
);

  import gbn_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  always_comb begin
    free      = !valid_r || out_ready;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ----- rtl/gbn_ctrl.sv -----
// Window controller: counters, timer and item sequencer around the slot byte RAM.
// Depends on gbn_pkg; drives gbn_byte_ram and gbn_out_reg.
module gbn_ctrl #(
  parameter int WINDOW   = gbn_pkg::WINDOW_DEF,
  parameter int SEQ_BITS = gbn_pkg::SEQ_BITS_DEF,
  parameter int AW       = $clog2(WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gbn_pkg::kind_t                in_kind,
  input  logic [gbn_pkg::PAYLOAD_W-1:0] in_payload,
  input  logic [gbn_pkg::ACK_W-1:0]     in_ack_num,
  input  logic [gbn_pkg::TIMER_W-1:0]   timeout,
  input  logic                          out_free,
  output logic                          res_load,
  output gbn_pkg::res_t                 res,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [gbn_pkg::PAYLOAD_W-1:0] ram_wdata,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [gbn_pkg::PAYLOAD_W-1:0] ram_rdata
);

  import gbn_pkg::*;

  localparam int CW  = $clog2(WINDOW + 1);
  localparam longint SPACE = longint'(64'd1 << SEQ_BITS);
  localparam int CAP = (longint'(WINDOW) < SPACE) ? WINDOW : int'(SPACE - 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAP);

  state_t               state_r, state_nxt;
  kind_t                kind_r, kind_nxt;
  logic [PAYLOAD_W-1:0] payload_r, payload_nxt;
  logic [SEQ_BITS-1:0]  ack_r, ack_nxt;
  logic [SEQ_BITS-1:0]  base_seq_r, base_seq_nxt;
  logic [SEQ_BITS-1:0]  next_seq_r, next_seq_nxt;
  logic [AW-1:0]        base_slot_r, base_slot_nxt;
  logic [CW-1:0]        unsent_r, unsent_nxt;
  logic [CW-1:0]        pending_r, pending_nxt;
  logic [TIMER_W-1:0]   timer_r, timer_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 retx_r, retx_nxt;

  logic                 done;
  logic                 go_read;
  logic [CW-1:0]        occ;
  logic [CW-1:0]        idx_inc;
  logic [SEQ_BITS-1:0]  off_seq;
  logic [CW-1:0]        off_c;
  logic                 ack_ign;
  logic [TIMER_W-1:0]   limit;
  logic [TIMER_W-1:0]   timer_inc;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] b, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(o);
    if (s >= (CW+1)'(WINDOW)) begin
      s = s - (CW+1)'(WINDOW);
    end
    return AW'(s);
  endfunction

  assign occ       = CW'(pending_r + unsent_r);
  assign idx_inc   = CW'(idx_r + 1'b1);
  assign off_seq   = SEQ_BITS'(ack_r - base_seq_r);
  assign off_c     = CW'(off_seq);
  assign ack_ign   = (off_seq == '0) || (off_seq > SEQ_BITS'(occ));
  assign limit     = (timeout == '0) ? TIMER_W'(1) : timeout;
  assign timer_inc = (timer_r == TIMER_MAX) ? timer_r : TIMER_W'(timer_r + 1'b1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go_read) begin
          state_nxt = ST_READ;
        end else if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    done          = 1'b0;
    go_read       = 1'b0;
    res_load      = 1'b0;
    res           = '0;
    res.kind      = OUT_STATUS;
    res.free      = CNT_OUT_W'(CAP_C - occ);
    res.waiting   = CNT_OUT_W'(pending_r);
    ram_we        = 1'b0;
    ram_waddr     = slot_of(base_slot_r, occ);
    ram_wdata     = payload_r;
    ram_re        = 1'b0;
    ram_raddr     = slot_of(base_slot_r, idx_r);
    kind_nxt      = kind_r;
    payload_nxt   = payload_r;
    ack_nxt       = ack_r;
    base_seq_nxt  = base_seq_r;
    next_seq_nxt  = next_seq_r;
    base_slot_nxt = base_slot_r;
    unsent_nxt    = unsent_r;
    pending_nxt   = pending_r;
    timer_nxt     = timer_r;
    idx_nxt       = idx_r;
    retx_nxt      = retx_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt    = in_kind;
          payload_nxt = in_payload;
          ack_nxt     = SEQ_BITS'(in_ack_num);
        end
      end
      ST_EXEC: begin
        res.last = 1'b1;
        case (kind_r)
          KIND_PRODUCE: begin
            if (out_free) begin
              res_load = 1'b1;
              done     = 1'b1;
              res.seq  = FSEQ_W'(next_seq_r);
              if (occ >= CAP_C) begin
                res.kind = OUT_REFUSED;
              end else begin
                ram_we       = 1'b1;
                res.data     = payload_r;
                res.free     = CNT_OUT_W'(CAP_C - occ - 1'b1);
                next_seq_nxt = SEQ_BITS'(next_seq_r + 1'b1);
                unsent_nxt   = CW'(unsent_r + 1'b1);
              end
            end
          end
          KIND_SEND: begin
            if (unsent_r == '0) begin
              if (out_free) begin
                res_load = 1'b1;
                done     = 1'b1;
                res.seq  = FSEQ_W'(next_seq_r);
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = slot_of(base_slot_r, pending_r);
              idx_nxt   = pending_r;
              retx_nxt  = 1'b0;
              go_read   = 1'b1;
            end
          end
          KIND_ACK: begin
            if (out_free) begin
              res_load  = 1'b1;
              done      = 1'b1;
              timer_nxt = '0;
              res.seq   = FSEQ_W'(ack_r);
              if (ack_ign) begin
                res.kind = OUT_ACK_IGN;
              end else begin
                base_seq_nxt  = ack_r;
                base_slot_nxt = slot_of(base_slot_r, off_c);
                if (off_c <= pending_r) begin
                  pending_nxt = CW'(pending_r - off_c);
                end else begin
                  pending_nxt = '0;
                  unsent_nxt  = CW'(occ - off_c);
                end
                res.free    = CNT_OUT_W'(CAP_C - CW'(occ - off_c));
                res.waiting = CNT_OUT_W'(pending_nxt);
              end
            end
          end
          KIND_TICK: begin
            if (pending_r != '0 && timer_inc >= limit) begin
              timer_nxt = '0;
              ram_re    = 1'b1;
              ram_raddr = base_slot_r;
              idx_nxt   = '0;
              retx_nxt  = 1'b1;
              go_read   = 1'b1;
            end else if (out_free) begin
              res_load  = 1'b1;
              done      = 1'b1;
              res.seq   = FSEQ_W'(base_seq_r);
              timer_nxt = (pending_r == '0) ? '0 : timer_inc;
            end
          end
          default: done = 1'b1;
        endcase
      end
      ST_READ: begin
        if (out_free) begin
          res_load = 1'b1;
          res.seq  = FSEQ_W'(SEQ_BITS'(base_seq_r + SEQ_BITS'(idx_r)));
          res.data = ram_rdata;
          if (retx_r) begin
            res.kind = OUT_RETX;
            res.last = (idx_inc == pending_r);
            if (idx_inc == pending_r) begin
              done = 1'b1;
            end else begin
              idx_nxt   = idx_inc;
              ram_re    = 1'b1;
              ram_raddr = slot_of(base_slot_r, idx_inc);
            end
          end else begin
            res.kind    = OUT_SENT;
            res.last    = 1'b1;
            done        = 1'b1;
            pending_nxt = CW'(pending_r + 1'b1);
            unsent_nxt  = CW'(unsent_r - 1'b1);
            res.waiting = CNT_OUT_W'(pending_nxt);
            if (pending_r == '0) begin
              timer_nxt = '0;
            end
          end
        end
      end
      default: done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_seq_r  <= '0;
      next_seq_r  <= '0;
      base_slot_r <= '0;
      unsent_r    <= '0;
      pending_r   <= '0;
      timer_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      base_seq_r  <= base_seq_nxt;
      next_seq_r  <= next_seq_nxt;
      base_slot_r <= base_slot_nxt;
      unsent_r    <= unsent_nxt;
      pending_r   <= pending_nxt;
      timer_r     <= timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    payload_r <= payload_nxt;
    ack_r     <= ack_nxt;
    idx_r     <= idx_nxt;
    retx_r    <= retx_nxt;
  end

  a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= CAP_C)
    else $error("window occupancy above capacity");

  a_seq_span: assert property (@(posedge clk) disable iff (!rst_n)
    SEQ_BITS'(next_seq_r - base_seq_r) == SEQ_BITS'(occ))
    else $error("sequence span disagrees with slot counts");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result loaded into a full output register");

  a_retx_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && retx_r) |-> (idx_r < pending_r))
    else $error("retransmit index beyond waiting frames");

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && !out_free) |=> $stable(ram_rdata))
    else $error("read data lost while output stalled");

endmodule

// ----- rtl/go_back_n_sender_window_core.sv -----
// Top level of the go-back-N sender window: stream ports, timeout register,
// field packing. Depends on gbn_pkg, gbn_byte_ram, gbn_out_reg and gbn_ctrl.
//
//   channel  dir  handshake               contents
//   in_      in   in_tvalid / in_tready   tuser: kind; tdata: payload, ack_num
//   out_     out  out_tvalid / out_tready tuser: out_kind; tlast: last;
//                                         tdata: frame_seq, frame_data,
//                                                free_slots, waiting_count
//   cfg_     in   cfg_wr_en               cfg_wr_data: timeout_ticks
//
// Produce, ack and plain status items pass through accept and execute; a send
// adds a byte RAM read state after execute. A timeout tick retransmits the N
// waiting frames, one byte RAM read and one result per cycle unless out_tready stalls.
// Reset is synchronous, active low; the byte RAM is not cleared.
// A stalled out_tready holds the result and the item in flight.
module go_back_n_sender_window_core #(
  parameter int WINDOW   = gbn_pkg::WINDOW_DEF,
  parameter int SEQ_BITS = gbn_pkg::SEQ_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // payload[7:0], ack_num[23:8]
  input  logic [1:0]  in_tuser,     // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // frame_seq[15:0], frame_data[23:16],
                                    // free_slots[27:24], waiting_count[31:28]
  output logic [2:0]  out_tuser,    // out_kind[2:0]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  import gbn_pkg::*;

  localparam int AW = $clog2(WINDOW);

  logic [TIMER_W-1:0]   timeout_r, timeout_nxt;
  logic                 out_free;
  logic                 res_load;
  res_t                 res_in;
  res_t                 res_out;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [PAYLOAD_W-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [PAYLOAD_W-1:0] ram_rdata;

  always_comb begin
    timeout_nxt = timeout_r;
    if (cfg_wr_en) begin
      timeout_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  gbn_ctrl #(
    .WINDOW   (WINDOW),
    .SEQ_BITS (SEQ_BITS),
    .AW       (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (kind_t'(in_tuser)),
    .in_payload (in_tdata[PAYLOAD_W-1:0]),
    .in_ack_num (in_tdata[IN_TDATA_W-1:PAYLOAD_W]),
    .timeout    (timeout_r),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res_in),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  gbn_byte_ram #(
    .DEPTH (WINDOW),
    .AW    (AW),
    .DW    (PAYLOAD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gbn_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res_in    (res_in),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_out)
  );

  assign out_tdata = {res_out.waiting, res_out.free, res_out.data, res_out.seq};
  assign out_tuser = res_out.kind;
  assign out_tlast = res_out.last;

endmodule
